// File: hw/rtl/assert_macros.svh
// assertion macros shared by the scorer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define GPCC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gpcc check failed");

// clocked check that also holds during reset
`define GPCC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("gpcc check failed");

`endif

// File: hw/rtl/gpcc_pkg.sv
// shared types and constants of the genotype pattern case/control scorer
// no dependencies; used by the interfaces and all scorer modules
package gpcc_pkg;

   // fixed field widths
   localparam int GENO_BITS        = 8;
   localparam int COLUMN_BITS      = 16;
   localparam int WANTED_BITS      = 2;
   localparam int ORDER_BITS       = 2;
   localparam int COUNT_FIELD_BITS = 20;
   localparam int SCORE_BITS       = 38;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORDER      = 3'd0,
      CSR_COLUMN_A   = 3'd1,
      CSR_COLUMN_B   = 3'd2,
      CSR_COLUMN_C   = 3'd3,
      CSR_WANTED_A   = 3'd4,
      CSR_WANTED_B   = 3'd5,
      CSR_WANTED_C   = 3'd6,
      CSR_SCORE_MODE = 3'd7
   } csr_index_type;

   // score mode codes
   localparam logic MODE_RATIO      = 1'b0;
   localparam logic MODE_DIFFERENCE = 1'b1;

   // configuration register set
   typedef struct packed {
      logic [ORDER_BITS-1:0]  order;
      logic [COLUMN_BITS-1:0] column_a;
      logic [COLUMN_BITS-1:0] column_b;
      logic [COLUMN_BITS-1:0] column_c;
      logic [WANTED_BITS-1:0] wanted_a;
      logic [WANTED_BITS-1:0] wanted_b;
      logic [WANTED_BITS-1:0] wanted_c;
      logic                   score_mode;
   } cfg_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: hw/rtl/gpcc_if.sv
// valid/ready channel interfaces of the scorer: request and response
// depends on gpcc_pkg for field widths
interface gpcc_req_if;
   logic                             valid;
   logic                             ready;
   logic [gpcc_pkg::GENO_BITS-1:0]   genotype;
   logic                             is_control;
   logic                             end_of_row;
   logic                             end_of_set;

   modport source (output valid, genotype, is_control, end_of_row, end_of_set,
                   input ready);
   modport sink (input valid, genotype, is_control, end_of_row, end_of_set,
                 output ready);
endinterface

interface gpcc_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [gpcc_pkg::COUNT_FIELD_BITS-1:0]    case_count;
   logic [gpcc_pkg::COUNT_FIELD_BITS-1:0]    control_count;
   logic signed [gpcc_pkg::SCORE_BITS-1:0]   score;

   modport source (output valid, case_count, control_count, score, input ready);
   modport sink (input valid, case_count, control_count, score, output ready);
endinterface

// File: hw/rtl/genotype_pattern_case_control_scorer_unit.sv
// Genotype pattern case/control scorer. Genotype bytes arrive one per request, row by
// row; while the block is idle it takes each request that is not the end of a set, so
// rows stream at one byte per clock. The end-of-set request closes the set: the setup
// state hands the operands to the shared restoring divider, which produces one
// quotient bit per cycle until the quotient is complete, and the response register is
// then loaded; no new request is taken until that load. The difference score also runs
// through the divider, with a divisor of one. A response waiting at the output does not
// stop row streaming; only a second finished score waits for it. Configuration is to
// be written through the csr port only while the block is idle; the block does not
// enforce this.
// depends on gpcc_pkg, gpcc_if, gpcc_matcher, gpcc_divider and assert_macros.svh
`include "assert_macros.svh"

module genotype_pattern_case_control_scorer_unit #(
   parameter int MAX_COLUMNS   = 65536,
   parameter int COUNT_BITS    = 20,
   parameter int FRACTION_BITS = 16,
   parameter int MAX_ORDER     = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   gpcc_req_if.sink                              req_bus,
   gpcc_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [gpcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gpcc_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   localparam int DIV_BITS  = COUNT_BITS + 1;
   localparam int QUO_BITS  = DIV_BITS + FRACTION_BITS;
   localparam int SB        = gpcc_pkg::SCORE_BITS;
   localparam int EXT_BITS  = ((QUO_BITS > SB) ? QUO_BITS : SB) + 1;
   localparam int CF        = gpcc_pkg::COUNT_FIELD_BITS;
   localparam int CW_BITS   = (COUNT_BITS > CF) ? COUNT_BITS : CF;
   localparam logic [EXT_BITS-1:0] POS_LIM = EXT_BITS'({1'b0, {(SB-1){1'b1}}});
   localparam logic [EXT_BITS-1:0] NEG_LIM = EXT_BITS'({1'b1, {(SB-1){1'b0}}});

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   state_type state_ff;
   gpcc_pkg::cfg_type cfg_ff, cfg_in;

   logic                                   rsp_valid_ff;
   logic [CF-1:0]                          case_count_ff, control_count_ff;
   logic signed [SB-1:0]                   score_ff;
   logic                                   neg_ff;

   logic                                   req_accept;
   logic [COUNT_BITS-1:0]                  total_case, total_control;
   gpcc_pkg::div_status_type               div_status;
   logic [QUO_BITS-1:0]                    quotient;
   logic                                   div_start;
   logic [DIV_BITS-1:0]                    numer, denom;
   logic                                   neg_in;
   logic                                   can_load, load;
   logic [EXT_BITS-1:0]                    mag_ext, mag_sat;
   logic [SB-1:0]                          score_next;
   logic [CW_BITS-1:0]                     case_wide, control_wide;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (gpcc_pkg::csr_index_type'(csr_index))
            gpcc_pkg::CSR_ORDER:      cfg_in.order      = csr_write_data[1:0];
            gpcc_pkg::CSR_COLUMN_A:   cfg_in.column_a   = csr_write_data;
            gpcc_pkg::CSR_COLUMN_B:   cfg_in.column_b   = csr_write_data;
            gpcc_pkg::CSR_COLUMN_C:   cfg_in.column_c   = csr_write_data;
            gpcc_pkg::CSR_WANTED_A:   cfg_in.wanted_a   = csr_write_data[1:0];
            gpcc_pkg::CSR_WANTED_B:   cfg_in.wanted_b   = csr_write_data[1:0];
            gpcc_pkg::CSR_WANTED_C:   cfg_in.wanted_c   = csr_write_data[1:0];
            gpcc_pkg::CSR_SCORE_MODE: cfg_in.score_mode = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.order      <= 2'd2;
         cfg_ff.column_a   <= 16'd0;
         cfg_ff.column_b   <= 16'd1;
         cfg_ff.column_c   <= 16'd2;
         cfg_ff.wanted_a   <= 2'd0;
         cfg_ff.wanted_b   <= 2'd0;
         cfg_ff.wanted_c   <= 2'd0;
         cfg_ff.score_mode <= gpcc_pkg::MODE_RATIO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request handshake
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;

   gpcc_matcher #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .COUNT_BITS  (COUNT_BITS),
      .MAX_ORDER   (MAX_ORDER)
   ) u_matcher (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (req_accept),
      .genotype      (req_bus.genotype),
      .is_control    (req_bus.is_control),
      .end_of_row    (req_bus.end_of_row),
      .end_of_set    (req_bus.end_of_set),
      .total_case    (total_case),
      .total_control (total_control)
   );

   // operand setup: ratio divides the larger of case+1, control+1 by the
   // smaller; difference divides the tally gap by one
   always_comb begin
      logic [DIV_BITS-1:0] c_inc;
      logic [DIV_BITS-1:0] k_inc;
      logic                case_ge;
      logic                control_ge;
      c_inc      = DIV_BITS'(total_case) + 1'b1;
      k_inc      = DIV_BITS'(total_control) + 1'b1;
      case_ge    = (total_case >= total_control);
      control_ge = (total_control >= total_case);
      if (cfg_ff.score_mode == gpcc_pkg::MODE_DIFFERENCE) begin
         numer  = control_ge ? DIV_BITS'(total_control - total_case)
                             : DIV_BITS'(total_case - total_control);
         denom  = DIV_BITS'(1);
         neg_in = !control_ge;
      end else begin
         numer  = case_ge ? c_inc : k_inc;
         denom  = case_ge ? k_inc : c_inc;
         neg_in = !case_ge;
      end
   end

   assign div_start = (state_ff == ST_SETUP);

   gpcc_divider #(
      .DIV_BITS  (DIV_BITS),
      .FRAC_BITS (FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (denom),
      .status   (div_status),
      .quotient (quotient)
   );

   // signed score with saturation to the output range
   assign mag_ext = EXT_BITS'(quotient);
   always_comb begin
      if (neg_ff) begin
         mag_sat    = (mag_ext > NEG_LIM) ? NEG_LIM : mag_ext;
         score_next = SB'(0) - mag_sat[SB-1:0];
      end else begin
         mag_sat    = (mag_ext > POS_LIM) ? POS_LIM : mag_ext;
         score_next = mag_sat[SB-1:0];
      end
   end

   assign case_wide    = CW_BITS'(total_case);
   assign control_wide = CW_BITS'(total_control);

   // response register load
   assign can_load = !rsp_valid_ff || rsp_bus.ready;
   assign load     = can_load && ((state_ff == ST_HOLD)
                  || ((state_ff == ST_DIVIDE) && div_status.done));

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_bus.end_of_set) state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_status.done) state_ff <= load ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
               if (load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
      if (div_start) neg_ff <= neg_in;
      if (load) begin
         case_count_ff    <= case_wide[CF-1:0];
         control_count_ff <= control_wide[CF-1:0];
         score_ff         <= score_next;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.case_count    = case_count_ff;
   assign rsp_bus.control_count = control_count_ff;
   assign rsp_bus.score         = score_ff;

   // checks
   `GPCC_ASSERT(a_setup_follows_set_end, clock, reset, (state_ff == ST_SETUP) |-> $past(req_accept && req_bus.end_of_set))
   `GPCC_ASSERT(a_no_request_while_dividing, clock, reset, div_status.busy |-> !req_bus.ready)
   `GPCC_ASSERT(a_done_only_in_divide, clock, reset, div_status.done |-> (state_ff == ST_DIVIDE))
   `GPCC_ASSERT(a_positive_score_sign, clock, reset, (load && !neg_ff) |-> !score_next[SB-1])

endmodule

// File: hw/rtl/gpcc_matcher.sv
// row matcher: tracks the column position, checks the selected columns and
// keeps the saturating case/control tallies; depends on gpcc_pkg
module gpcc_matcher #(
   parameter int MAX_COLUMNS = 65536,
   parameter int COUNT_BITS  = 20,
   parameter int MAX_ORDER   = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gpcc_pkg::cfg_type                    cfg,
   input  logic                                 accept,
   input  logic [gpcc_pkg::GENO_BITS-1:0]       genotype,
   input  logic                                 is_control,
   input  logic                                 end_of_row,
   input  logic                                 end_of_set,
   output logic [COUNT_BITS-1:0]                total_case,
   output logic [COUNT_BITS-1:0]                total_control
);
   localparam int POS_BITS = $clog2(MAX_COLUMNS);
   localparam int CMP_BITS = (POS_BITS > gpcc_pkg::COLUMN_BITS) ? POS_BITS
                                                                : gpcc_pkg::COLUMN_BITS;
   localparam logic [POS_BITS-1:0]   POS_LAST  = POS_BITS'(MAX_COLUMNS - 1);
   localparam logic [COUNT_BITS-1:0] TALLY_MAX = {COUNT_BITS{1'b1}};

   logic [POS_BITS-1:0]   position_ff, position_in;
   logic                  row_match_ff, row_match_in;
   logic [COUNT_BITS-1:0] case_tally_ff, case_tally_in;
   logic [COUNT_BITS-1:0] control_tally_ff, control_tally_in;
   logic [COUNT_BITS-1:0] total_case_ff, total_case_in;
   logic [COUNT_BITS-1:0] total_control_ff, total_control_in;

   logic [gpcc_pkg::ORDER_BITS-1:0] active;
   logic [CMP_BITS-1:0]             cmp_pos;
   logic                            miss_a, miss_b, miss_c;
   logic                            row_ok;
   logic                            row_close;
   logic [COUNT_BITS-1:0]           case_upd, control_upd;

   // active column count, clamped to the largest supported order
   assign active = (cfg.order > gpcc_pkg::ORDER_BITS'(MAX_ORDER))
                 ? gpcc_pkg::ORDER_BITS'(MAX_ORDER) : cfg.order;

   // per-column mismatch checks
   assign cmp_pos = CMP_BITS'(position_ff);
   assign miss_a = (active >= 2'd1) && (cmp_pos == CMP_BITS'(cfg.column_a))
                && (genotype != gpcc_pkg::GENO_BITS'(cfg.wanted_a));
   assign miss_b = (active >= 2'd2) && (cmp_pos == CMP_BITS'(cfg.column_b))
                && (genotype != gpcc_pkg::GENO_BITS'(cfg.wanted_b));
   assign miss_c = (active == 2'd3) && (cmp_pos == CMP_BITS'(cfg.column_c))
                && (genotype != gpcc_pkg::GENO_BITS'(cfg.wanted_c));
   assign row_ok    = row_match_ff && !miss_a && !miss_b && !miss_c;
   assign row_close = end_of_row || end_of_set;

   // tallies including the row that closes now
   always_comb begin
      case_upd    = case_tally_ff;
      control_upd = control_tally_ff;
      if (row_close && row_ok) begin
         if (is_control) begin
            if (control_tally_ff != TALLY_MAX) control_upd = control_tally_ff + 1'b1;
         end else begin
            if (case_tally_ff != TALLY_MAX) case_upd = case_tally_ff + 1'b1;
         end
      end
   end

   // next state of position, row flag, tallies and set totals
   always_comb begin
      position_in      = position_ff;
      row_match_in     = row_match_ff;
      case_tally_in    = case_tally_ff;
      control_tally_in = control_tally_ff;
      total_case_in    = total_case_ff;
      total_control_in = total_control_ff;
      if (accept) begin
         if (row_close) begin
            position_in  = '0;
            row_match_in = 1'b1;
         end else begin
            row_match_in = row_ok;
            if (position_ff < POS_LAST) position_in = position_ff + 1'b1;
         end
         if (end_of_set) begin
            total_case_in    = case_upd;
            total_control_in = control_upd;
            case_tally_in    = '0;
            control_tally_in = '0;
         end else begin
            case_tally_in    = case_upd;
            control_tally_in = control_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         row_match_ff     <= 1'b1;
         case_tally_ff    <= '0;
         control_tally_ff <= '0;
      end else begin
         position_ff      <= position_in;
         row_match_ff     <= row_match_in;
         case_tally_ff    <= case_tally_in;
         control_tally_ff <= control_tally_in;
      end
      total_case_ff    <= total_case_in;
      total_control_ff <= total_control_in;
   end

   assign total_case    = total_case_ff;
   assign total_control = total_control_ff;

endmodule

// File: hw/rtl/gpcc_divider.sv
// shared restoring divider: one quotient bit per cycle of (numer << frac) / denom
// depends on gpcc_pkg for the status struct
module gpcc_divider #(
   parameter int DIV_BITS  = 21,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIV_BITS-1:0]               numer,
   input  logic [DIV_BITS-1:0]               denom,
   output gpcc_pkg::div_status_type          status,
   output logic [DIV_BITS+FRAC_BITS-1:0]     quotient
);
   localparam int QUO_BITS = DIV_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic [QUO_BITS-1:0] shift_ff, shift_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] denom_ff, denom_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [DIV_BITS:0] partial;
   logic [DIV_BITS:0] trial;
   logic              fits;

   // one trial subtraction per cycle
   assign partial = {rem_ff, shift_ff[QUO_BITS-1]};
   assign trial   = partial - {1'b0, denom_ff};
   assign fits    = !trial[DIV_BITS];

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = {numer, {FRAC_BITS{1'b0}}};
         rem_in   = '0;
         denom_in = denom;
         count_in = CNT_BITS'(QUO_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[QUO_BITS-2:0], fits};
         rem_in   = fits ? trial[DIV_BITS-1:0] : partial[DIV_BITS-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff;

endmodule

// File: test/gpcc_score_checker.sv
// scoreboard of the genotype pattern scorer: mirrors the csr writes, predicts each score
// from the accepted genotype requests and compares every accepted response field by field
// depends on gpcc_pkg and the gpcc_req_if / gpcc_rsp_if channel interfaces
module gpcc_score_checker
   import gpcc_pkg::*;
#(
   parameter int MAX_COLUMNS   = 65536,
   parameter int COUNT_BITS    = 20,
   parameter int FRACTION_BITS = 16,
   parameter int MAX_ORDER     = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   gpcc_req_if                       req_mon,
   gpcc_rsp_if                       rsp_mon,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int                        failures,
   output int                        pending_scores,
   output int                        scores_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned TALLY_MAX       = (64'd1 << COUNT_BITS) - 64'd1;
   localparam longint unsigned SCORE_POS_LIMIT = (64'd1 << (SCORE_BITS - 1)) - 64'd1;
   localparam longint unsigned SCORE_NEG_LIMIT = 64'd1 << (SCORE_BITS - 1);

   typedef struct packed {
      logic [COUNT_FIELD_BITS-1:0]  case_count;
      logic [COUNT_FIELD_BITS-1:0]  control_count;
      logic signed [SCORE_BITS-1:0] score;
   } score_record_type;

   // mirrored registers and scan state
   cfg_type            settings;
   int unsigned        column_position;
   bit                 row_matches;
   longint unsigned    case_tally;
   longint unsigned    control_tally;
   score_record_type   expected_scores[$];

   // fitness in fixed point, truncated toward zero and clamped to the score width
   function automatic logic signed [SCORE_BITS-1:0] fitness_of(input longint unsigned cases,
                                                               input longint unsigned controls,
                                                               input logic mode);
      longint unsigned num;
      longint unsigned den;
      longint unsigned mag;
      bit              neg;
      if (mode == MODE_DIFFERENCE) begin
         neg = cases > controls;
         mag = (neg ? cases - controls : controls - cases) << FRACTION_BITS;
      end else begin
         num = cases + 64'd1;
         den = controls + 64'd1;
         neg = num < den;
         mag = neg ? (den << FRACTION_BITS) / num : (num << FRACTION_BITS) / den;
      end
      if (neg && mag > SCORE_NEG_LIMIT) mag = SCORE_NEG_LIMIT;
      if (!neg && mag > SCORE_POS_LIMIT) mag = SCORE_POS_LIMIT;
      return neg ? SCORE_BITS'(64'd0 - mag) : SCORE_BITS'(mag);
   endfunction

   always @(posedge clock) begin : predict_and_compare
      score_record_type seen;
      score_record_type want;
      int unsigned      active;
      if (reset) begin
         settings = '{order: 2'd2, column_a: 16'd0, column_b: 16'd1, column_c: 16'd2,
                      wanted_a: 2'd0, wanted_b: 2'd0, wanted_c: 2'd0, score_mode: MODE_RATIO};
         column_position = 0;
         row_matches = 1'b1;
         case_tally = 0;
         control_tally = 0;
         expected_scores.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_ORDER:      settings.order = csr_write_data[ORDER_BITS-1:0];
               CSR_COLUMN_A:   settings.column_a = csr_write_data[COLUMN_BITS-1:0];
               CSR_COLUMN_B:   settings.column_b = csr_write_data[COLUMN_BITS-1:0];
               CSR_COLUMN_C:   settings.column_c = csr_write_data[COLUMN_BITS-1:0];
               CSR_WANTED_A:   settings.wanted_a = csr_write_data[WANTED_BITS-1:0];
               CSR_WANTED_B:   settings.wanted_b = csr_write_data[WANTED_BITS-1:0];
               CSR_WANTED_C:   settings.wanted_c = csr_write_data[WANTED_BITS-1:0];
               CSR_SCORE_MODE: settings.score_mode = csr_write_data[0];
               default: ;
            endcase
         end

         // response against the oldest expected score
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.case_count, rsp_mon.control_count, rsp_mon.score};
            if (expected_scores.size() == 0) begin
               $error("unexpected response: case_count %0d, control_count %0d, score %0d",
                      seen.case_count, seen.control_count, seen.score);
               failures++;
            end else begin
               want = expected_scores.pop_front();
               scores_checked++;
               if (seen.case_count !== want.case_count) begin
                  $error("case_count mismatch: expected %0d, actual %0d",
                         want.case_count, seen.case_count);
                  failures++;
               end
               if (seen.control_count !== want.control_count) begin
                  $error("control_count mismatch: expected %0d, actual %0d",
                         want.control_count, seen.control_count);
                  failures++;
               end
               if (seen.score !== want.score) begin
                  $error("score mismatch: expected %0d, actual %0d", want.score, seen.score);
                  failures++;
               end
            end
         end

         // genotype request: column checks, row close, set close
         if (req_mon.valid && req_mon.ready) begin
            active = (settings.order > MAX_ORDER) ? MAX_ORDER : settings.order;
            if (active >= 1 && column_position == settings.column_a &&
                req_mon.genotype != settings.wanted_a)
               row_matches = 1'b0;
            if (active >= 2 && column_position == settings.column_b &&
                req_mon.genotype != settings.wanted_b)
               row_matches = 1'b0;
            if (active >= 3 && column_position == settings.column_c &&
                req_mon.genotype != settings.wanted_c)
               row_matches = 1'b0;

            if (req_mon.end_of_row || req_mon.end_of_set) begin
               if (row_matches) begin
                  if (req_mon.is_control) begin
                     if (control_tally < TALLY_MAX) control_tally++;
                  end else begin
                     if (case_tally < TALLY_MAX) case_tally++;
                  end
               end
               column_position = 0;
               row_matches = 1'b1;
            end else if (column_position < MAX_COLUMNS - 1) begin
               column_position++;
            end

            if (req_mon.end_of_set) begin
               want.case_count = case_tally[COUNT_FIELD_BITS-1:0];
               want.control_count = control_tally[COUNT_FIELD_BITS-1:0];
               want.score = fitness_of(case_tally, control_tally, settings.score_mode);
               expected_scores.insert(expected_scores.size(), want);
               case_tally = 0;
               control_tally = 0;
            end
         end
      end
      pending_scores = expected_scores.size();
   end

endmodule

// File: test/tb_genotype_pattern_case_control_scorer_unit.sv
// testbench top of the genotype pattern scorer: clock, reset, csr writes, genotype stream
// and response back-pressure; checking is done by gpcc_score_checker
// depends on gpcc_pkg, gpcc_if, gpcc_score_checker and the scorer rtl
module tb_genotype_pattern_case_control_scorer_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import gpcc_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 60;
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 535;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_enable;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;
   int      hold_requests = 0;
   int      items_sent = 0;
   int      sets_sent = 0;
   int      settings_written = 0;
   int      quiet_cycles = 0;
   cfg_type settings_now;

   int failures;
   int pending_scores;
   int scores_checked;

   gpcc_req_if req_bus();
   gpcc_rsp_if rsp_bus();

   genotype_pattern_case_control_scorer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gpcc_score_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending_scores   (pending_scores),
      .scores_checked   (scores_checked)
   );

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // watchdog on cycles without any accepted request, response or register write
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("genotype_pattern_case_control_scorer_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls plus a long hold-off on demand
   initial begin : response_drain
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // one genotype request, with random idle cycles ahead of it
   task automatic push_request(input logic [GENO_BITS-1:0] genotype, input logic is_control,
                               input logic end_of_row, input logic end_of_set);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.genotype <= genotype;
      req_bus.is_control <= is_control;
      req_bus.end_of_row <= end_of_row;
      req_bus.end_of_set <= end_of_set;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
      if (end_of_set) sets_sent++;
   endtask

   // full register set, written only once the scorer has drained
   task automatic write_settings(input cfg_type s);
      int            i;
      csr_index_type idx;
      req_bus.valid <= 1'b0;
      while (pending_scores != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      for (i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_ORDER:      csr_write_data <= CSR_DATA_BITS'(s.order);
            CSR_COLUMN_A:   csr_write_data <= CSR_DATA_BITS'(s.column_a);
            CSR_COLUMN_B:   csr_write_data <= CSR_DATA_BITS'(s.column_b);
            CSR_COLUMN_C:   csr_write_data <= CSR_DATA_BITS'(s.column_c);
            CSR_WANTED_A:   csr_write_data <= CSR_DATA_BITS'(s.wanted_a);
            CSR_WANTED_B:   csr_write_data <= CSR_DATA_BITS'(s.wanted_b);
            CSR_WANTED_C:   csr_write_data <= CSR_DATA_BITS'(s.wanted_c);
            default:        csr_write_data <= CSR_DATA_BITS'(s.score_mode);
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= idx;
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      settings_now = s;
      settings_written++;
   endtask

   // mostly columns inside short rows, sometimes the last column or anywhere
   function automatic logic [COLUMN_BITS-1:0] pick_column();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return COLUMN_BITS'($urandom);
         default: return COLUMN_BITS'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.order = ORDER_BITS'($urandom_range(0, 3));
      s.column_a = pick_column();
      s.column_b = pick_column();
      s.column_c = pick_column();
      s.wanted_a = ($urandom_range(0, 9) == 0) ? 2'd3 : WANTED_BITS'($urandom_range(0, 2));
      s.wanted_b = ($urandom_range(0, 9) == 0) ? 2'd3 : WANTED_BITS'($urandom_range(0, 2));
      s.wanted_c = ($urandom_range(0, 9) == 0) ? 2'd3 : WANTED_BITS'($urandom_range(0, 2));
      s.score_mode = $urandom_range(0, 1) ? MODE_DIFFERENCE : MODE_RATIO;
      return s;
   endfunction

   // one set of rows; most rows aim at the pattern, the rest are noise
   task automatic send_random_set();
      int                   rows;
      int                   row_len;
      int                   r;
      int                   p;
      bit                   aim;
      logic                 row_class;
      logic [GENO_BITS-1:0] g;
      rows = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (r = 0; r < rows; r++) begin
         row_len = (rows > 10) ? $urandom_range(1, 3) : $urandom_range(1, 8);
         aim = $urandom_range(0, 99) < 65;
         row_class = 1'($urandom_range(0, 1));
         for (p = 0; p < row_len; p++) begin
            g = ($urandom_range(0, 9) < 7) ? GENO_BITS'($urandom_range(0, 3))
                                           : GENO_BITS'($urandom_range(0, 255));
            if (aim) begin
               if (settings_now.order >= 3 && p == settings_now.column_c)
                  g = GENO_BITS'(settings_now.wanted_c);
               if (settings_now.order >= 2 && p == settings_now.column_b)
                  g = GENO_BITS'(settings_now.wanted_b);
               if (settings_now.order >= 1 && p == settings_now.column_a)
                  g = GENO_BITS'(settings_now.wanted_a);
            end
            if (p == row_len - 1 && r == rows - 1)
               push_request(g, row_class, 1'($urandom_range(0, 1)), 1'b1);
            else if (p == row_len - 1)
               push_request(g, row_class, 1'b1, 1'b0);
            else
               push_request(g, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
         end
      end
   endtask

   // random sets under changing settings until the phase has its requests
   task automatic run_phase(input int sender_pct, input int receiver_pct, input bit squeeze);
      int start;
      int n;
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         write_settings(random_settings());
         if (squeeze) begin
            hold_requests++;
            squeeze = 1'b0;
         end
         n = $urandom_range(3, 8);
         repeat (n) begin
            if (items_sent - start < PHASE_ITEMS) send_random_set();
         end
      end
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.genotype <= '0;
      req_bus.is_control <= 1'b0;
      req_bus.end_of_row <= 1'b0;
      req_bus.end_of_set <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_ORDER;
      csr_write_data <= '0;
      settings_now = '{order: 2'd2, column_a: 16'd0, column_b: 16'd1, column_c: 16'd2,
                       wanted_a: 2'd0, wanted_b: 2'd0, wanted_c: 2'd0, score_mode: MODE_RATIO};
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: two columns, ratio score
      push_request(8'd0, 1'b0, 1'b0, 1'b0);
      push_request(8'd0, 1'b1, 1'b0, 1'b0);
      push_request(8'd255, 1'b0, 1'b1, 1'b0);   // third column not active at order two
      push_request(8'd0, 1'b1, 1'b0, 1'b0);
      push_request(8'd1, 1'b1, 1'b1, 1'b0);     // control row fails at second column
      push_request(8'd0, 1'b1, 1'b0, 1'b0);
      push_request(8'd0, 1'b1, 1'b1, 1'b0);
      push_request(8'd0, 1'b0, 1'b0, 1'b1);     // set end alone closes a short case row

      // no active column: every row matches, difference score
      write_settings('{order: 2'd0, column_a: '1, column_b: '1, column_c: '1,
                       wanted_a: 2'd3, wanted_b: 2'd3, wanted_c: 2'd3,
                       score_mode: MODE_DIFFERENCE});
      push_request(8'hAA, 1'b1, 1'b1, 1'b0);
      push_request(8'h55, 1'b1, 1'b1, 1'b0);
      push_request(8'h03, 1'b0, 1'b1, 1'b1);

      // all three columns, out of order, negative ratio
      write_settings('{order: 2'd3, column_a: 16'd2, column_b: 16'd0, column_c: 16'd1,
                       wanted_a: 2'd2, wanted_b: 2'd3, wanted_c: 2'd1,
                       score_mode: MODE_RATIO});
      push_request(8'd3, 1'b0, 1'b0, 1'b0);
      push_request(8'd1, 1'b0, 1'b0, 1'b0);
      push_request(8'd2, 1'b1, 1'b1, 1'b0);     // class taken from the row's last request
      push_request(8'd3, 1'b1, 1'b0, 1'b0);
      push_request(8'd1, 1'b0, 1'b0, 1'b0);
      push_request(8'd2, 1'b1, 1'b1, 1'b0);
      push_request(8'd3, 1'b0, 1'b0, 1'b0);
      push_request(8'd1, 1'b1, 1'b0, 1'b0);
      push_request(8'd0, 1'b0, 1'b0, 1'b1);

      // random phases: receiver stalls more, then sender, then none with a long hold-off
      run_phase(23, 56, 1'b0);
      run_phase(56, 23, 1'b0);
      run_phase(0, 0, 1'b1);

      // drain
      req_bus.valid <= 1'b0;
      while (pending_scores != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d genotype requests in %0d sets under %0d register settings",
               items_sent, sets_sent, settings_written);
      $display("compared %0d scores, including a long response hold-off", scores_checked);
      if (failures == 0 && pending_scores == 0)
         $display("genotype_pattern_case_control_scorer_unit verification clean");
      else
         $display("genotype_pattern_case_control_scorer_unit verification failed");
      $finish;
   end

endmodule
